// ----- hdl/csr_spmv_pkg.sv -----
// Shared types, codes and constants of the CSR sparse matrix-vector multiply unit.
package csr_spmv_pkg;

  // Default depth of the vector store, in 32-bit words.
  localparam int unsigned VEC_DEPTH_DEF = 1024;

  // Field widths of the input and result words.
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned COL_W    = 10;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned VLEN_W   = 11;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned IN_DW    = 48;
  localparam int unsigned OUT_DW   = 48;

  // Column index widened far enough to compare against any store depth below 2^17.
  localparam int unsigned COL_XW   = 17;

  // Configuration port.
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 16;
  localparam logic [CFG_AW-1:0] REG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_AW-1:0] REG_ROW_COUNT     = 2'd1;

  localparam logic [VLEN_W-1:0] VLEN_RST = 11'd1024;
  localparam logic [ROW_W-1:0]  ROWS_RST = 16'd1;

  // Input word kinds, carried on in_tuser.
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NONZERO = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE   = 2'd2;

  // Result status codes, carried on out_tuser.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_COL = 2'd1;
  localparam logic [STAT_W-1:0] ST_EXCESS  = 2'd2;

  // Saturation limits of a Q16.16 result.
  localparam logic [VAL_W-1:0] SUM_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] SUM_MIN = 32'h8000_0000;

  // Output queue. A word can be in flight in three pipeline stages, plus the
  // word accepted in the current cycle, so the queue keeps that much headroom.
  localparam int unsigned OFIFO_DEPTH  = 8;
  localparam int unsigned OFIFO_AW     = 3;
  localparam int unsigned OFIFO_CW     = 4;
  localparam int unsigned PIPE_RESULTS = 4;
  localparam logic [OFIFO_CW-1:0] OFIFO_RDY_LIMIT = OFIFO_CW'(OFIFO_DEPTH - PIPE_RESULTS);

  typedef struct packed {
    logic [VAL_W-1:0]  row_sum;
    logic [ROW_W-1:0]  row_number;
    logic              last_row;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

// ----- hdl/csr_sparse_matrix_vector_multiply_unit.sv -----
// Top level of the CSR sparse matrix-vector multiply unit: vector store, MAC pipeline, result queue.
//
// Usage: the input stream carries three kinds of words, selected by in_tuser.
// A load word writes one element of the vector x into the on-chip vector store.
// A nonzero word carries a column and a matrix value; the unit multiplies it
// with the stored vector element and adds the Q32.32 product to a 64-bit row
// accumulator. in_tlast on a nonzero word marks it as the last of its row, and
// a close word ends a row that has no entries. Each ended row gives one result
// word: the rounded and saturated Q16.16 sum and the row number on out_tdata,
// the status on out_tuser and the final-row flag on out_tlast.
// Throughput is one input word per clock cycle while in_tready is high, set
// by the registered read of the vector store and the one multiply and one
// accumulate stage per word. The word that closes a row passes stages 1 to 3
// and the result queue. Results wait in an eight-word queue; when out_tready
// is held low the unit keeps accepting input until the queue, counting the
// words still in the pipeline, could fill, and then drops in_tready.
// Reset (rst_n low, synchronous) clears the accumulator, the row counter, the
// pipeline and the queue and restores the register defaults; the vector store
// is not cleared and must be loaded before it is used.
module csr_sparse_matrix_vector_multiply_unit
  import csr_spmv_pkg::*;
#(
  parameter int unsigned VEC_DEPTH = VEC_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration write port.
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // Input stream.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // column [9:0], value [41:10], zero [47:42]
  input  logic [FUNC_W-1:0] in_tuser,   // func [1:0]
  input  logic              in_tlast,   // ends_row
  // Result stream.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // row_sum [31:0], row_number [47:32]
  output logic [STAT_W-1:0] out_tuser,  // status [1:0]
  output logic              out_tlast   // last_row
);

  localparam int unsigned AW = $clog2(VEC_DEPTH);

  // Configuration registers.
  logic [VLEN_W-1:0] vec_len_r;
  logic [ROW_W-1:0]  row_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_len_r <= VLEN_RST;
      row_cnt_r <= ROWS_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_VECTOR_LENGTH) begin
        vec_len_r <= cfg_wdata[VLEN_W-1:0];
      end else if (cfg_addr == REG_ROW_COUNT) begin
        row_cnt_r <= cfg_wdata[ROW_W-1:0];
      end
    end
  end

  // Input decode.
  logic               in_fire;
  logic [COL_W-1:0]   in_col;
  logic [VAL_W-1:0]   in_val;
  logic [COL_XW-1:0]  col_ext;
  logic               col_in_store;
  logic               col_in_len;
  logic [AW-1:0]      mem_addr;
  logic               is_load;
  logic               is_nz;
  logic               is_close;

  assign in_fire      = in_tvalid && in_tready;
  assign in_col       = in_tdata[COL_W-1:0];
  assign in_val       = in_tdata[COL_W+VAL_W-1:COL_W];
  assign col_ext      = {{(COL_XW-COL_W){1'b0}}, in_col};
  assign col_in_store = col_ext < COL_XW'(VEC_DEPTH);
  assign col_in_len   = {1'b0, in_col} < vec_len_r;
  assign mem_addr     = col_ext[AW-1:0];
  assign is_load      = in_fire && (in_tuser == FUNC_LOAD);
  assign is_nz        = in_fire && (in_tuser == FUNC_NONZERO);
  assign is_close     = in_fire && (in_tuser == FUNC_CLOSE);

  // Vector store: one write port for loads, one registered read for nonzeros.
  // Both happen at acceptance, so a nonzero right after a load sees its data.
  logic [VAL_W-1:0]        vec_mem [VEC_DEPTH];
  logic signed [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (is_load && col_in_store) begin
      vec_mem[mem_addr] <= in_val;
    end
    if (is_nz) begin
      rd_data_r <= vec_mem[mem_addr];
    end
  end

  // Stage 1: word is waiting for its vector element.
  logic                    s1_vld_r;
  logic                    s1_mac_r;
  logic                    s1_bad_r;
  logic                    s1_close_r;
  logic signed [VAL_W-1:0] s1_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= is_nz || is_close;
    end
    s1_mac_r   <= is_nz && col_in_store && col_in_len;
    s1_bad_r   <= is_nz && !(col_in_store && col_in_len);
    s1_close_r <= is_close || (is_nz && in_tlast);
    s1_val_r   <= in_val;
  end

  // Stage 2: product register.
  logic                    s2_vld_r;
  logic                    s2_mac_r;
  logic                    s2_bad_r;
  logic                    s2_close_r;
  logic signed [ACC_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_mac_r   <= s1_mac_r;
    s2_bad_r   <= s1_bad_r;
    s2_close_r <= s1_close_r;
    prod_r     <= ACC_W'(s1_val_r) * ACC_W'(rd_data_r);
  end

  // Stage 3: accumulate and, on a row end, latch the row result.
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;
  logic              bad_seen_r;
  logic              bad_nxt;
  logic [ROW_W-1:0]  cur_row_r;
  logic              row_excess;
  logic              row_last;
  logic              s3_vld_r;
  logic [ACC_W-1:0]  fin_acc_r;
  logic [ROW_W-1:0]  fin_row_r;
  logic              fin_last_r;
  logic [STAT_W-1:0] fin_status_r;

  assign acc_nxt    = acc_r + (s2_mac_r ? prod_r : '0);
  assign bad_nxt    = bad_seen_r || s2_bad_r;
  assign row_excess = cur_row_r >= row_cnt_r;
  assign row_last   = ({1'b0, cur_row_r} + 17'd1) == {1'b0, row_cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      bad_seen_r <= 1'b0;
      cur_row_r  <= '0;
      s3_vld_r   <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r && s2_close_r;
      if (s2_vld_r) begin
        if (s2_close_r) begin
          acc_r      <= '0;
          bad_seen_r <= 1'b0;
          if (!row_excess) begin
            cur_row_r <= row_last ? '0 : cur_row_r + 16'd1;
          end
        end else begin
          acc_r      <= acc_nxt;
          bad_seen_r <= bad_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r && s2_close_r) begin
      fin_acc_r  <= row_excess ? '0 : acc_nxt;
      fin_row_r  <= cur_row_r;
      fin_last_r <= !row_excess && row_last;
      if (row_excess) begin
        fin_status_r <= ST_EXCESS;
      end else if (bad_nxt) begin
        fin_status_r <= ST_BAD_COL;
      end else begin
        fin_status_r <= ST_OK;
      end
    end
  end

  // Round Q32.32 to Q16.16 (a half rounds up) and saturate to 32 bits.
  logic [ACC_W-16:0] rnd;
  logic              rnd_fits;
  res_t              res_in;

  assign rnd      = {fin_acc_r[ACC_W-1], fin_acc_r[ACC_W-1:16]} + {48'd0, fin_acc_r[15]};
  assign rnd_fits = (&rnd[ACC_W-16:31]) || !(|rnd[ACC_W-16:31]);

  always_comb begin
    res_in.row_number = fin_row_r;
    res_in.last_row   = fin_last_r;
    res_in.status     = fin_status_r;
    if (rnd_fits) begin
      res_in.row_sum = rnd[VAL_W-1:0];
    end else if (rnd[ACC_W-16]) begin
      res_in.row_sum = SUM_MIN;
    end else begin
      res_in.row_sum = SUM_MAX;
    end
  end

  // Result queue.
  res_t                q_mem [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] q_wr_r;
  logic [OFIFO_AW-1:0] q_rd_r;
  logic [OFIFO_CW-1:0] q_cnt_r;
  logic                q_push;
  logic                q_pop;
  res_t                q_head;

  assign q_push = s3_vld_r;
  assign q_pop  = out_tvalid && out_tready;
  assign q_head = q_mem[q_rd_r];

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr_r] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (q_push) begin
        q_wr_r <= q_wr_r + 3'd1;
      end
      if (q_pop) begin
        q_rd_r <= q_rd_r + 3'd1;
      end
      unique case ({q_push, q_pop})
        2'b10:   q_cnt_r <= q_cnt_r + 4'd1;
        2'b01:   q_cnt_r <= q_cnt_r - 4'd1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

  // Input is taken only while the queue can absorb every word in flight.
  assign in_tready  = q_cnt_r <= OFIFO_RDY_LIMIT;

  assign out_tvalid = q_cnt_r != '0;
  assign out_tdata  = {q_head.row_number, q_head.row_sum};
  assign out_tuser  = q_head.status;
  assign out_tlast  = q_head.last_row;

endmodule
